### rtl/ipv4e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4e_pkg
// Types, constants and the ones'-complement adder shared by the IPv4 receive
// classifier and its byte parser.
// ----------------------------------------------------------------------------
package ipv4e_pkg;

   localparam logic [7:0]  IP_VER_IHL        = 8'h45;
   localparam logic [7:0]  PROTO_ICMP        = 8'd1;
   localparam logic [7:0]  PROTO_UDP         = 8'd17;
   localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
   localparam logic [31:0] ADDR_BROADCAST    = 32'hffff_ffff;
   localparam logic [3:0]  MCAST_NIBBLE      = 4'he;
   localparam logic [15:0] SUM_GOOD          = 16'hffff;

   // byte positions in the packet (count saturates at POS_SAT)
   localparam logic [4:0]  POS_HDR_END       = 5'd20;
   localparam logic [4:0]  POS_ICMP_FULL     = 5'd24;
   localparam logic [4:0]  POS_SAT           = 5'd24;

   typedef enum logic [1:0] {
      VERDICT_PASS = 2'd0,
      VERDICT_DROP = 2'd1,
      VERDICT_UDP  = 2'd2,
      VERDICT_ECHO = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  protocol_number;
      logic        is_broadcast;
      logic        is_multicast;
      logic        icmp_checksum_ok;
      logic [31:0] source_address;
      logic [15:0] reply_header_checksum;
      logic [15:0] reply_icmp_checksum;
   } rsp_type;

   // packet state as it stands once the current byte is taken in
   typedef struct packed {
      logic [4:0]  byte_count;
      logic [7:0]  first_byte;
      logic [7:0]  protocol;
      logic [7:0]  icmp_type;
      logic [31:0] source;
      logic [31:0] destination;
      logic [15:0] icmp_sum;
      logic [15:0] header_sum;
      logic [15:0] reply_icmp_sum;
   } snapshot_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

### rtl/ipv4e_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4e_parser
// Per-byte header capture and running ones'-complement sums; presents the
// updated packet state for the byte being accepted.
// ----------------------------------------------------------------------------
module ipv4e_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  ipv4e_pkg::req_type      req,
   output ipv4e_pkg::snapshot_type snap
);
   import ipv4e_pkg::*;

   localparam logic [4:0] POS_FIRST    = 5'd0;
   localparam logic [4:0] POS_PROTO    = 5'd9;
   localparam logic [4:0] POS_SRC_LO   = 5'd12;
   localparam logic [4:0] POS_SRC_HI   = 5'd15;
   localparam logic [4:0] POS_DST_LO   = 5'd16;
   localparam logic [4:0] POS_DST_HI   = 5'd19;
   localparam logic [4:0] POS_HDR_MID  = 5'd8;
   localparam logic [4:0] POS_SRC_W1   = 5'd14;
   localparam logic [4:0] POS_ICMP_CS  = 5'd22;

   logic [4:0]  count_ff, count_in;
   logic        odd_ff, odd_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  proto_ff, proto_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] icmp_ff, icmp_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [15:0] ricmp_ff, ricmp_in;

   logic [15:0] word;
   logic [4:0]  hi_pos;
   logic        do_add;
   logic [7:0]  b;

   assign b = req.data_byte;

   always_comb begin
      // the high byte of a word is held; a lone final byte pads with zero
      word     = odd_ff ? {held_ff, b} : {b, 8'h00};
      hi_pos   = odd_ff ? (count_ff - 5'd1) : count_ff;
      do_add   = odd_ff | req.last_byte;

      odd_in   = ~odd_ff;
      held_in  = odd_ff ? held_ff : b;
      count_in = (count_ff < POS_SAT) ? (count_ff + 5'd1) : POS_SAT;

      first_in = (count_ff == POS_FIRST) ? b : first_ff;
      proto_in = (count_ff == POS_PROTO) ? b : proto_ff;
      type_in  = (count_ff == POS_HDR_END) ? b : type_ff;
      src_in   = (count_ff >= POS_SRC_LO && count_ff <= POS_SRC_HI) ?
                 {src_ff[23:0], b} : src_ff;
      dst_in   = (count_ff >= POS_DST_LO && count_ff <= POS_DST_HI) ?
                 {dst_ff[23:0], b} : dst_ff;

      hdr_in   = hdr_ff;
      icmp_in  = icmp_ff;
      ricmp_in = ricmp_ff;
      if (do_add) begin
         priority if (hi_pos < POS_HDR_END) begin
            // reply header: leave out the checksum field and the destination address
            if (hi_pos <= POS_HDR_MID || hi_pos == POS_SRC_LO || hi_pos == POS_SRC_W1) begin
               hdr_in = oc_add(hdr_ff, word);
            end
         end else if (hi_pos == POS_HDR_END) begin
            // reply type is zero: keep only the code byte
            icmp_in  = oc_add(icmp_ff, word);
            ricmp_in = oc_add(ricmp_ff, {8'h00, word[7:0]});
         end else if (hi_pos == POS_ICMP_CS) begin
            icmp_in  = oc_add(icmp_ff, word);
         end else begin
            icmp_in  = oc_add(icmp_ff, word);
            ricmp_in = oc_add(ricmp_ff, word);
         end
      end
   end

   always_comb begin
      snap.byte_count     = count_in;
      snap.first_byte     = first_in;
      snap.protocol       = proto_in;
      snap.icmp_type      = type_in;
      snap.source         = src_in;
      snap.destination    = dst_in;
      snap.icmp_sum       = icmp_in;
      snap.header_sum     = hdr_in;
      snap.reply_icmp_sum = ricmp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_byte)) begin
         count_ff <= '0;
         odd_ff   <= 1'b0;
         held_ff  <= '0;
         first_ff <= '0;
         proto_ff <= '0;
         type_ff  <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         icmp_ff  <= '0;
         hdr_ff   <= '0;
         ricmp_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         odd_ff   <= odd_in;
         held_ff  <= held_in;
         first_ff <= first_in;
         proto_ff <= proto_in;
         type_ff  <= type_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         icmp_ff  <= icmp_in;
         hdr_ff   <= hdr_in;
         ricmp_ff <= ricmp_in;
      end
   end

`ifndef SYNTHESIS
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= POS_SAT)
      else $error("byte count beyond saturation");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req.last_byte |=> count_ff == '0 && !odd_ff)
      else $error("packet state not cleared after final byte");
   a_odd_parity: assert property (@(posedge clock) disable iff (reset)
      count_ff < POS_SAT |-> odd_ff == count_ff[0])
      else $error("word parity out of step with byte count");
`endif

endmodule

### rtl/ipv4_icmp_echo_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_icmp_echo_receiver
// IPv4 receive classifier with ICMP echo reply checksum generation.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one packet byte per request, wire order from the IPv4 header,
//            req.last_byte set on the final byte of the packet.
//   rsp_*  : one verdict per packet, produced from the final byte.
//   csr_*  : write of the local interface address; always ready, and to be
//            written only while no packet is in flight.
// Throughput: one byte per cycle while no response is stalled. Each
//   completed word costs one end-around-carry add per running sum that it
//   feeds in the parser; the final byte adds the folded local address into
//   the reply header sum in the same cycle. The result is in the response
//   register in the cycle after the final byte is accepted.
// Reset clears the packet state, the local address and the response valid
//   flag. While a response waits with rsp_ready low, req_ready drops,
//   so no byte is taken until that response is delivered; a response taken
//   in the same cycle frees the register at once.
// ----------------------------------------------------------------------------
module ipv4_icmp_echo_receiver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ipv4e_pkg::req_type req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ipv4e_pkg::rsp_type rsp,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data
);
   import ipv4e_pkg::*;

   logic         accept;
   logic         finish;
   snapshot_type snap;

   logic [15:0]  local_sum_ff, local_sum_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         bc, mc, ok, short_pkt;
   logic [15:0]  hsum;
   verdict_type  verdict;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign finish    = accept && req.last_byte;
   assign csr_ready = 1'b1;

   ipv4e_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .snap   (snap)
   );

   // hold the address pre-folded; zero only when the address is zero
   assign local_sum_in = oc_add(csr_data[31:16], csr_data[15:0]);

   always_comb begin
      bc        = snap.destination == ADDR_BROADCAST;
      mc        = snap.destination[31:28] == MCAST_NIBBLE;
      ok        = snap.icmp_sum == SUM_GOOD;
      short_pkt = snap.byte_count < POS_HDR_END;
      hsum      = oc_add(snap.header_sum, local_sum_ff);

      verdict = VERDICT_PASS;
      if (snap.first_byte == IP_VER_IHL) begin
         priority if (snap.protocol == PROTO_UDP) begin
            verdict = VERDICT_UDP;
         end else if (snap.protocol == PROTO_ICMP) begin
            priority if (local_sum_ff == '0 || mc || !ok) begin
               verdict = VERDICT_PASS;
            end else if (snap.byte_count < POS_ICMP_FULL) begin
               verdict = VERDICT_DROP;
            end else if (snap.icmp_type == ICMP_ECHO_REQUEST) begin
               verdict = VERDICT_ECHO;
            end else begin
               verdict = VERDICT_PASS;
            end
         end else begin
            verdict = VERDICT_PASS;
         end
      end

      if (short_pkt) begin
         rsp_in = '0;
         rsp_in.verdict = VERDICT_DROP;
      end else begin
         rsp_in.verdict               = verdict;
         rsp_in.protocol_number       = snap.protocol;
         rsp_in.is_broadcast          = bc;
         rsp_in.is_multicast          = mc;
         rsp_in.icmp_checksum_ok      = ok;
         rsp_in.source_address        = snap.source;
         rsp_in.reply_header_checksum = ~hsum;
         rsp_in.reply_icmp_checksum   = ~snap.reply_icmp_sum;
      end
   end

   always_comb begin
      priority if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         local_sum_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            local_sum_ff <= local_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && req_ready && req.last_byte))
      else $error("response raised without a final byte");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !accept)
      else $error("request taken while response stalled");
   a_echo_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.verdict == VERDICT_ECHO |->
         rsp_ff.protocol_number == PROTO_ICMP && !rsp_ff.is_multicast &&
         rsp_ff.icmp_checksum_ok)
      else $error("echo verdict on a packet that does not qualify");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid straight after reset");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives IPv4 packets byte by byte into the receive classifier and checks
// every verdict against a predictor kept alongside the stimulus. Directed
// packets cover short, malformed, UDP, multicast, broadcast and ICMP echo
// cases. Random packets are mostly sealed echo requests, mixed with noise,
// under several idling and stalling patterns and several local addresses.
// ----------------------------------------------------------------------------
module testbench;
   import ipv4e_pkg::*;

   localparam int LATENCY_GUARD  = 3;
   localparam int PHASE_BYTES    = 64;
   localparam logic [4:0] HDR_TTL_POS   = 5'd8;
   localparam logic [4:0] HDR_PROTO_POS = 5'd9;
   localparam logic [4:0] HDR_SRC_POS   = 5'd12;
   localparam logic [4:0] HDR_DST_POS   = 5'd16;
   localparam logic [4:0] ICMP_CSUM_POS = 5'd22;
   localparam logic [7:0] PROTO_TCP     = 8'd6;
   localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [31:0] csr_data = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;

   rsp_type     pending_verdicts[$];
   logic [7:0]  pkt_bytes[$];

   // predictor state
   logic [31:0] local_addr = '0;
   logic [4:0]  rx_count = '0;
   logic        rx_odd = 1'b0;
   logic [7:0]  rx_hi = '0;
   logic [7:0]  rx_first = '0;
   logic [7:0]  rx_proto = '0;
   logic [7:0]  rx_type = '0;
   logic [31:0] rx_src = '0;
   logic [31:0] rx_dst = '0;
   logic [15:0] sum_icmp = '0;
   logic [15:0] sum_hdr = '0;
   logic [15:0] sum_reply = '0;

   ipv4_icmp_echo_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic clear_packet_state();
      rx_count = '0;
      rx_odd = 1'b0;
      rx_hi = '0;
      rx_first = '0;
      rx_proto = '0;
      rx_type = '0;
      rx_src = '0;
      rx_dst = '0;
      sum_icmp = '0;
      sum_hdr = '0;
      sum_reply = '0;
   endtask

   task automatic add_word(input logic [4:0] hi_pos, input logic [15:0] w);
      if (hi_pos < POS_HDR_END) begin
         // reply header: checksum word left out, our source becomes its destination
         if (hi_pos <= HDR_TTL_POS || hi_pos == HDR_SRC_POS || hi_pos == HDR_SRC_POS + 5'd2)
            sum_hdr = fold_add(sum_hdr, w);
      end else if (hi_pos == POS_HDR_END) begin
         sum_icmp = fold_add(sum_icmp, w);
         // reply type is zero, only the code byte survives
         sum_reply = fold_add(sum_reply, {8'h00, w[7:0]});
      end else if (hi_pos == ICMP_CSUM_POS) begin
         sum_icmp = fold_add(sum_icmp, w);
      end else begin
         sum_icmp = fold_add(sum_icmp, w);
         sum_reply = fold_add(sum_reply, w);
      end
   endtask

   task automatic classify_byte(input logic [7:0] b, input logic last);
      logic [4:0]  pos;
      logic [15:0] hs;
      rsp_type     e;
      pos = rx_count;
      if (pos == 5'd0) rx_first = b;
      if (pos == HDR_PROTO_POS) rx_proto = b;
      if (pos >= HDR_SRC_POS && pos < HDR_DST_POS) rx_src = {rx_src[23:0], b};
      if (pos >= HDR_DST_POS && pos < POS_HDR_END) rx_dst = {rx_dst[23:0], b};
      if (pos == POS_HDR_END) rx_type = b;
      if (!rx_odd) begin
         rx_hi = b;
         rx_odd = 1'b1;
      end else begin
         add_word(pos - 5'd1, {rx_hi, b});
         rx_odd = 1'b0;
      end
      rx_count = (pos < POS_SAT) ? pos + 5'd1 : POS_SAT;
      if (last) begin
         // pad an odd final byte with a zero low byte
         if (rx_odd) add_word(pos, {rx_hi, 8'h00});
         e = '0;
         if (rx_count < POS_HDR_END) begin
            e.verdict = VERDICT_DROP;
         end else begin
            e.is_broadcast = (rx_dst == ADDR_BROADCAST);
            e.is_multicast = (rx_dst[31:28] == MCAST_NIBBLE);
            e.icmp_checksum_ok = (sum_icmp == SUM_GOOD);
            e.verdict = VERDICT_PASS;
            if (rx_first == IP_VER_IHL) begin
               if (rx_proto == PROTO_UDP) begin
                  e.verdict = VERDICT_UDP;
               end else if (rx_proto == PROTO_ICMP && local_addr != '0 &&
                            !e.is_multicast && e.icmp_checksum_ok) begin
                  if (rx_count < POS_ICMP_FULL) e.verdict = VERDICT_DROP;
                  else if (rx_type == ICMP_ECHO_REQUEST) e.verdict = VERDICT_ECHO;
               end
            end
            e.protocol_number = rx_proto;
            e.source_address = rx_src;
            hs = fold_add(fold_add(sum_hdr, local_addr[31:16]), local_addr[15:0]);
            e.reply_header_checksum = ~hs;
            e.reply_icmp_checksum = ~sum_reply;
         end
         pending_verdicts.push_back(e);
         clear_packet_state();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected verdict", {30'd0, rsp.verdict}, '0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp.verdict != want.verdict)
               report_mismatch("verdict", 32'(rsp.verdict), 32'(want.verdict));
            if (rsp.protocol_number != want.protocol_number)
               report_mismatch("protocol_number", 32'(rsp.protocol_number),
                               32'(want.protocol_number));
            if (rsp.is_broadcast != want.is_broadcast)
               report_mismatch("is_broadcast", 32'(rsp.is_broadcast),
                               32'(want.is_broadcast));
            if (rsp.is_multicast != want.is_multicast)
               report_mismatch("is_multicast", 32'(rsp.is_multicast),
                               32'(want.is_multicast));
            if (rsp.icmp_checksum_ok != want.icmp_checksum_ok)
               report_mismatch("icmp_checksum_ok", 32'(rsp.icmp_checksum_ok),
                               32'(want.icmp_checksum_ok));
            if (rsp.source_address != want.source_address)
               report_mismatch("source_address", rsp.source_address, want.source_address);
            if (rsp.reply_header_checksum != want.reply_header_checksum)
               report_mismatch("reply_header_checksum", 32'(rsp.reply_header_checksum),
                               32'(want.reply_header_checksum));
            if (rsp.reply_icmp_checksum != want.reply_icmp_checksum)
               report_mismatch("reply_icmp_checksum", 32'(rsp.reply_icmp_checksum),
                               32'(want.reply_icmp_checksum));
         end
      end
   end

   // one byte per request; valid stays high into the next call unless idling
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99, 0) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req.data_byte <= b;
      req.last_byte <= last;
      do @(posedge clock); while (!req_ready);
      classify_byte(b, last);
   endtask

   task automatic send_packet();
      int i;
      for (i = 0; i < pkt_bytes.size(); i++)
         send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
   endtask

   // hold the sender until every verdict is in
   task automatic await_verdicts();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (LATENCY_GUARD) @(posedge clock);
   endtask

   task automatic write_local_address(input logic [31:0] addr);
      await_verdicts();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= addr;
      do @(posedge clock); while (!csr_ready);
      local_addr = addr;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic build_stub(input int len);
      int i;
      pkt_bytes.delete();
      for (i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom_range(255, 0)));
   endtask

   // header plus body; seal makes the ICMP part sum to all ones
   task automatic build_packet(input logic [7:0] first, input logic [7:0] proto,
                               input logic [31:0] dst, input int body_len,
                               input logic [7:0] kind, input bit seal);
      int          i;
      int          fix;
      logic [15:0] s;
      build_stub(20 + body_len);
      pkt_bytes[0] = first;
      pkt_bytes[HDR_PROTO_POS] = proto;
      for (i = 0; i < 4; i++) pkt_bytes[HDR_DST_POS + i] = dst[31 - 8 * i -: 8];
      if (body_len > 0) pkt_bytes[POS_HDR_END] = kind;
      if (seal && body_len >= 2) begin
         fix = (body_len >= 4) ? int'(ICMP_CSUM_POS) : int'(POS_HDR_END);
         pkt_bytes[fix] = 8'h00;
         pkt_bytes[fix + 1] = 8'h00;
         s = '0;
         for (i = int'(POS_HDR_END); i < pkt_bytes.size(); i += 2)
            s = fold_add(s, {pkt_bytes[i], (i + 1 < pkt_bytes.size()) ? pkt_bytes[i + 1] : 8'h00});
         s = ~s;
         pkt_bytes[fix] = s[15:8];
         pkt_bytes[fix + 1] = s[7:0];
      end
   endtask

   function automatic logic [31:0] random_destination();
      case ($urandom_range(9, 0))
         0: return ADDR_BROADCAST;
         1: return {MCAST_NIBBLE, 28'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   task automatic test_short_packets();
      build_stub(1);
      send_packet();
      build_stub(2);
      send_packet();
      build_stub(19);
      send_packet();
      // local address still at its reset value: echo is not answered
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0001, 8, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0001, 0, ICMP_ECHO_REQUEST, 1);
      send_packet();
   endtask

   task automatic test_icmp_cases();
      write_local_address($urandom());
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0002, 0, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0002, 2, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0002, 3, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0002, 4, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0002, 9, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0002, 8, ICMP_ECHO_REQUEST, 0);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0002, 8, ICMP_ECHO_REPLY, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'he000_0001, 8, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, ADDR_BROADCAST, 8, ICMP_ECHO_REQUEST, 1);
      send_packet();
   endtask

   task automatic test_other_headers();
      build_packet(IP_VER_IHL, PROTO_UDP, 32'h0a00_0003, 8, 8'h00, 0);
      send_packet();
      build_packet(IP_VER_IHL, PROTO_TCP, 32'h0a00_0003, 8, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(8'h46, PROTO_ICMP, 32'h0a00_0003, 8, ICMP_ECHO_REQUEST, 1);
      send_packet();
      build_packet(8'h46, PROTO_UDP, 32'h0a00_0003, 8, 8'h00, 0);
      send_packet();
   endtask

   task automatic test_field_extremes();
      int i;
      write_local_address(32'hffff_ffff);
      build_stub(24);
      for (i = 0; i < 24; i++) pkt_bytes[i] = 8'hff;
      send_packet();
      for (i = 0; i < 24; i++) pkt_bytes[i] = 8'h00;
      send_packet();
      build_packet(IP_VER_IHL, PROTO_ICMP, 32'h0a00_0004, 8, ICMP_ECHO_REQUEST, 1);
      send_packet();
      write_local_address(32'h0000_0001);
      send_packet();
   endtask

   task automatic test_random_traffic(input int idle, input int stall,
                                      input logic [31:0] addr);
      int sent;
      int len;
      write_local_address(addr);
      idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < PHASE_BYTES) begin
         len = ($urandom_range(11, 0) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 4);
         case ($urandom_range(99, 0)) inside
            [0:54]:
               build_packet(IP_VER_IHL, PROTO_ICMP, random_destination(), len,
                            ($urandom_range(9, 0) == 0) ? 8'($urandom()) : ICMP_ECHO_REQUEST,
                            $urandom_range(19, 0) != 0);
            [55:69]:
               build_packet(IP_VER_IHL, PROTO_UDP, random_destination(),
                            $urandom_range(20, 0), 8'($urandom()), 0);
            [70:79]:
               build_packet(IP_VER_IHL, PROTO_ICMP, random_destination(),
                            $urandom_range(3, 0), ICMP_ECHO_REQUEST, 1);
            [80:87]:
               build_packet($urandom_range(3, 0) == 0 ? IP_VER_IHL : 8'($urandom()),
                            8'($urandom()), random_destination(), len, 8'($urandom()),
                            1'($urandom_range(1, 0)));
            default:
               build_stub($urandom_range(30, 1));
         endcase
         send_packet();
         sent += pkt_bytes.size();
         if ($urandom_range(7, 0) == 0) await_verdicts();
      end
      await_verdicts();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_short_packets();
      test_icmp_cases();
      test_other_headers();
      test_field_extremes();
      test_random_traffic(0, 0, $urandom());
      test_random_traffic(80, 0, 32'hffff_ffff);
      test_random_traffic(0, 80, 32'h0000_0000);
      test_random_traffic(10, 10, $urandom());
      test_random_traffic(0, 0, $urandom());
      await_verdicts();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
